/* rtl/core/elgamal_message_cipher_defines.svh */
// Assertion macros shared by the cipher RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ELGAMAL_MESSAGE_CIPHER_DEFINES_SVH
`define ELGAMAL_MESSAGE_CIPHER_DEFINES_SVH

// Condition must hold on every clock edge out of reset.
`define EMC_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("emc check failed");

// Antecedent one cycle implies consequent on the next.
`define EMC_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emc sequence check failed");

`endif

/* rtl/core/emc_pkg.sv */
// Shared types and constants for the ElGamal message cipher.
// No dependencies; imported by emc_modmul, elgamal_message_cipher and the testbench.
package emc_pkg;

    localparam int MOD_BITS = 31;
    localparam int CNT_W    = $clog2(MOD_BITS);

    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PUBLIC    = 2'd2;
    localparam logic [1:0] REG_PRIVATE   = 2'd3;

    typedef logic [MOD_BITS-1:0] word_t;

    typedef struct packed {
        logic  start;
        word_t a;   // must be below m
        word_t b;   // any value
        word_t m;
    } mul_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t result;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_RED_X,
        ST_RED_BASE,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_POW_END,
        ST_SYM,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/emc_modmul.sv */
// Bit-serial modular multiplier: double-and-add, one modular add per cycle.
// Depends on emc_pkg for word width and request/response structs.
module emc_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  emc_pkg::mul_req_t req,
    output emc_pkg::mul_rsp_t rsp
);
    import emc_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             ph_reg;
    logic [CNT_W-1:0] cnt_reg;
    word_t            acc_reg;
    word_t            a_reg;
    word_t            b_reg;
    word_t            m_reg;
    word_t            acc_next;

    // x, y below m
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        word_t room;
        room = m - y;
        if (x >= room)
            add_mod = x - room;
        else
            add_mod = x + y;
    endfunction

    always_comb
    begin
        if (!ph_reg)
            acc_next = add_mod(acc_reg, acc_reg, m_reg);
        else if (b_reg[MOD_BITS-1])
            acc_next = add_mod(acc_reg, a_reg, m_reg);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    ph_reg   <= 1'b0;
                    cnt_reg  <= '0;
                    acc_reg  <= '0;
                    a_reg    <= req.a;
                    b_reg    <= req.b;
                    m_reg    <= req.m;
                end
            end
            else
            begin
                acc_reg <= acc_next;
                ph_reg  <= ~ph_reg;
                if (ph_reg)
                begin
                    b_reg   <= {b_reg[MOD_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MOD_BITS-1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // modulus of zero or one yields zero
    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = (m_reg < word_t'(2)) ? '0 : acc_reg;

endmodule

/* rtl/core/elgamal_message_cipher.sv */
// Top level of the ElGamal message cipher: stream ports, config, sequencer.
// Depends on emc_pkg, emc_modmul and elgamal_message_cipher_defines.svh.
//
// Channel   Dir  Handshake            Content
// s_*       in   s_tvalid/s_tready    one symbol with op, first flag, r, c1
// m_*       out  m_tvalid/m_tready    c1_out, symbol_out, bad flag, last
// cfg_*     in   cfg_valid/cfg_ready  register index and 31-bit value
//
// An item that is not first runs from one input transfer to the next through idle,
// prep, the symbol multiply (start, busy, done) and done.
// A first item adds modular exponentiations: a base reduction, then per exponent
// bit a squaring and a multiply for a set bit (encrypt runs two of them; decrypt
// may add a key fold).
// Reset clears the session factor to one and config to its defaults.
// A finished result sits in the output register, so the next input transfer
// can start while m_tready is low; only a second result waits for it.
`include "elgamal_message_cipher_defines.svh"
module elgamal_message_cipher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [95:0]            s_tdata,   // ephemeral, c1_in, symbol, zero pad
    input  logic [1:0]             s_tuser,   // operation, first
    input  logic                   s_tlast,   // last_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,   // c1_out, symbol_out, zero pad
    output logic [0:0]             m_tuser,   // bad_symbol
    output logic                   m_tlast,   // last_out
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [emc_pkg::MOD_BITS-1:0] cfg_data
);
    import emc_pkg::*;

    // configuration
    word_t p_reg, g_reg, y_reg, x_reg;

    // latched input item
    logic  op_reg, first_reg, last_reg;
    word_t r_reg, c1in_reg, sym_reg;

    // sequencer
    state_t           state_reg, state_next;
    logic             issued_reg;
    logic             pass_reg;     // encrypt: 0 builds c1, 1 builds the factor
    logic [CNT_W-1:0] cnt_reg;
    word_t            exp_reg, base_reg, acc_reg;
    word_t            factor_reg, c1res_reg, symres_reg;

    // output register
    logic  mv_reg, mbad_reg, mlast_reg;
    word_t mc1_reg, msym_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    logic  s_fire, bad, p_small, x_big, out_free, want_mul;
    word_t p_m1, pow_val;

    assign s_fire   = s_tvalid && s_tready;
    assign bad      = (sym_reg >= p_reg);
    assign p_small  = (p_reg < word_t'(2));
    assign p_m1     = p_reg - word_t'(1);
    assign x_big    = (x_reg > p_m1);
    assign out_free = !mv_reg || m_tready;
    assign pow_val  = p_small ? '0 : acc_reg;

    emc_modmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_fire)
                    state_next = ST_PREP;
            ST_PREP:
                if (!first_reg)
                    state_next = ST_SYM;
                else if (!op_reg)
                    state_next = ST_RED_BASE;
                else if (p_small)
                    state_next = ST_SYM;
                else if (x_big)
                    state_next = ST_RED_X;
                else
                    state_next = ST_RED_BASE;
            ST_RED_X:
                if (mrsp.done)
                    state_next = ST_RED_BASE;
            ST_RED_BASE:
                if (mrsp.done)
                    state_next = ST_POW_MUL;
            ST_POW_MUL:
                if (!exp_reg[0] || mrsp.done)
                    state_next = ST_POW_SQR;
            ST_POW_SQR:
                if (mrsp.done)
                    state_next = (cnt_reg == CNT_W'(MOD_BITS-1)) ? ST_POW_END : ST_POW_MUL;
            ST_POW_END:
                state_next = (!op_reg && !pass_reg) ? ST_RED_BASE : ST_SYM;
            ST_SYM:
                if (bad || mrsp.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier request and input ready
    always_comb
    begin
        want_mul = 1'b0;
        mreq.a   = word_t'(1);
        mreq.b   = x_reg;
        mreq.m   = p_reg;
        case (state_reg)
            ST_RED_X:
            begin
                want_mul = 1'b1;
                mreq.m   = p_m1;
            end
            ST_RED_BASE:
            begin
                want_mul = 1'b1;
                mreq.b   = op_reg ? c1in_reg : (pass_reg ? y_reg : g_reg);
            end
            ST_POW_MUL:
            begin
                want_mul = exp_reg[0];
                mreq.a   = acc_reg;
                mreq.b   = base_reg;
            end
            ST_POW_SQR:
            begin
                want_mul = 1'b1;
                mreq.a   = base_reg;
                mreq.b   = base_reg;
            end
            ST_SYM:
            begin
                // symbol is below p here, so it is the reduced operand
                want_mul = !bad;
                mreq.a   = sym_reg;
                mreq.b   = factor_reg;
            end
            default:
                want_mul = 1'b0;
        endcase
        mreq.start = want_mul && !issued_reg;
        s_tready   = (state_reg == ST_IDLE);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            factor_reg <= word_t'(1);
            mv_reg     <= 1'b0;
            p_reg      <= word_t'(257);
            g_reg      <= word_t'(3);
            y_reg      <= word_t'(3);
            x_reg      <= word_t'(1);
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODULUS:   p_reg <= cfg_data;
                    REG_GENERATOR: g_reg <= cfg_data;
                    REG_PUBLIC:    y_reg <= cfg_data;
                    REG_PRIVATE:   x_reg <= cfg_data;
                    default:       p_reg <= p_reg;
                endcase
            end

            if (mreq.start)
                issued_reg <= 1'b1;
            else if (mrsp.done)
                issued_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (s_fire)
                    begin
                        op_reg    <= s_tuser[0];
                        first_reg <= s_tuser[1];
                        r_reg     <= s_tdata[30:0];
                        c1in_reg  <= s_tdata[61:31];
                        sym_reg   <= s_tdata[92:62];
                        last_reg  <= s_tlast;
                    end
                ST_PREP:
                begin
                    pass_reg  <= 1'b0;
                    c1res_reg <= '0;
                    if (first_reg)
                    begin
                        if (!op_reg)
                            exp_reg <= r_reg;
                        else if (p_small)
                            factor_reg <= '0;
                        else if (!x_big)
                            exp_reg <= p_m1 - x_reg;
                    end
                end
                ST_RED_X:
                    if (mrsp.done)
                        exp_reg <= p_m1 - mrsp.result;
                ST_RED_BASE:
                    if (mrsp.done)
                    begin
                        base_reg <= mrsp.result;
                        acc_reg  <= word_t'(1);
                        cnt_reg  <= '0;
                    end
                ST_POW_MUL:
                    if (mrsp.done)
                        acc_reg <= mrsp.result;
                ST_POW_SQR:
                    if (mrsp.done)
                    begin
                        base_reg <= mrsp.result;
                        exp_reg  <= {1'b0, exp_reg[MOD_BITS-1:1]};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                ST_POW_END:
                    if (!op_reg && !pass_reg)
                    begin
                        c1res_reg <= pow_val;
                        pass_reg  <= 1'b1;
                        exp_reg   <= r_reg;
                    end
                    else
                        factor_reg <= pow_val;
                ST_SYM:
                    if (bad)
                        symres_reg <= '0;
                    else if (mrsp.done)
                        symres_reg <= mrsp.result;
                default:
                    cnt_reg <= cnt_reg;
            endcase

            // output register
            if (state_reg == ST_DONE && out_free)
            begin
                mv_reg    <= 1'b1;
                mc1_reg   <= c1res_reg;
                msym_reg  <= symres_reg;
                mbad_reg  <= bad;
                mlast_reg <= last_reg;
            end
            else if (m_tready)
                mv_reg <= 1'b0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, msym_reg, mc1_reg};
    assign m_tuser  = mbad_reg;
    assign m_tlast  = mlast_reg;

    `EMC_NEXT(a_accept_prep, s_fire, state_reg == ST_PREP)
    `EMC_CHECK(a_start_idle, !mreq.start || !mrsp.busy)
    `EMC_NEXT(a_load_done, !mv_reg && state_reg != ST_DONE, !mv_reg)

endmodule

/* sim/testbench.sv */
// Self-checking testbench for elgamal_message_cipher: directed table, then random sessions.
// Depends on emc_pkg and cipher RTL; checks use typed results or an in-bench predictor.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import emc_pkg::*;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;
    localparam word_t ALL_ONES = '1;

    // One symbol going in
    typedef struct {
        logic  op;
        logic  first;
        word_t eph;
        word_t c1;
        word_t sym;
        logic  last;
    } sym_in_t;

    // One cipher result
    typedef struct {
        word_t c1;
        word_t sym;
        logic  bad;
        logic  last;
    } cipher_out_t;

    // Directed row; known rows carry a hand-computed result
    typedef struct {
        sym_in_t     item;
        bit          known;
        cipher_out_t res;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // ephemeral, c1_in, symbol, zero pad
    logic [1:0]  s_tuser = '0;   // operation, first
    logic        s_tlast = 1'b0; // last_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // c1_out, symbol_out, zero pad
    logic [0:0]  m_tuser;        // bad_symbol
    logic        m_tlast;        // last_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    word_t       cfg_data = '0;

    elgamal_message_cipher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor copy of the block's registers and session state
    longint unsigned p_mod, p_gen, p_pub, p_priv, p_factor;

    cipher_out_t expected_results[$];
    int          mismatches = 0;
    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    bit          long_hold = 1'b0;
    bit          hold_req = 1'b0;

    function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned p);
        if (p < 2) return 0;
        return ((a % p) * (b % p)) % p;
    endfunction

    function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                                longint unsigned p);
        longint unsigned acc;
        if (p < 2) return 0;
        acc = 1;
        base = base % p;
        while (e != 0) begin
            if (e[0]) acc = mod_mul(acc, base, p);
            base = mod_mul(base, base, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Advances the session state and returns what the cipher should emit
    function automatic cipher_out_t cipher_predict(sym_in_t it);
        cipher_out_t     r;
        longint unsigned xr;
        r.c1 = '0;
        r.sym = '0;
        if (it.first) begin
            if (it.op == OP_ENCRYPT) begin
                r.c1 = word_t'(mod_pow(p_gen, it.eph, p_mod));
                p_factor = mod_pow(p_pub, it.eph, p_mod);
            end else if (p_mod < 2) begin
                p_factor = 0;
            end else begin
                // fold the private key into range before forming p-1-x
                xr = p_priv;
                if (xr > p_mod - 1) xr = xr % (p_mod - 1);
                p_factor = mod_pow(it.c1, (p_mod - 1) - xr, p_mod);
            end
        end
        r.bad = (it.sym >= p_mod);
        if (!r.bad) r.sym = word_t'(mod_mul(it.sym, p_factor, p_mod));
        r.last = it.last;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, word_t val);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge clk) rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODULUS:   p_mod  = val;
            REG_GENERATOR: p_gen  = val;
            REG_PUBLIC:    p_pub  = val;
            default:       p_priv = val;
        endcase
    endtask

    // Drives one symbol; on its transfer queues either the typed result or the prediction
    task automatic send_symbol(sym_in_t it, bit known, cipher_out_t typed);
        bit          rdy;
        cipher_out_t pred;
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.sym, it.c1, it.eph};
        s_tuser  <= {it.first, it.op};
        s_tlast  <= it.last;
        // tready sampled mid-cycle: stable until the next edge
        do begin
            @(negedge clk) rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
        pred = cipher_predict(it);
        expected_results.push_back(known ? typed : pred);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic word_t rand_word(longint unsigned p);
        case ($urandom_range(9))
            0:       return ALL_ONES;
            1:       return word_t'($urandom);
            2:       return word_t'(p - 1);
            3:       return '0;
            default: return word_t'($urandom % p);
        endcase
    endfunction

    // Plaintext: bytes or residues; ciphertext: mostly residues; a few out of range
    function automatic word_t rand_symbol(logic op, longint unsigned p);
        int unsigned k;
        k = $urandom_range(19);
        if (k == 0) return word_t'($urandom);
        if (k == 1) return word_t'(p + $urandom_range(3));
        if (k == 2) return ALL_ONES;
        if (op == OP_ENCRYPT && k < 12) return word_t'($urandom_range(255));
        return word_t'($urandom % p);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked
    always @(posedge clk) begin
        if (long_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        wait (hold_req);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (800) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Result checker; values sampled mid-cycle hold through the transfer edge
    always @(negedge clk) begin
        cipher_out_t got;
        cipher_out_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.c1 = m_tdata[30:0];
            got.sym = m_tdata[61:31];
            got.bad = m_tuser[0];
            got.last = m_tlast;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result c1=%0d sym=%0d bad=%0b last=%0b",
                             got.c1, got.sym, got.bad, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got.c1 !== want.c1 || got.sym !== want.sym ||
                    got.bad !== want.bad || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp c1=%0d sym=%0d bad=%0b last=%0b,",
                                  " got c1=%0d sym=%0d bad=%0b last=%0b"},
                                 want.c1, want.sym, want.bad, want.last,
                                 got.c1, got.sym, got.bad, got.last);
                end
            end
        end
    end

    // Generous fixed limit: first items run long modular exponentiations
    initial begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        table_row_t  dir_rows[$];
        cipher_out_t none;
        sym_in_t     it;
        int unsigned phase, n, len, j;
        longint unsigned mods[4];
        word_t       gens[4], privs[4], pubs[4];

        none = '{c1: '0, sym: '0, bad: 1'b0, last: 1'b0};
        p_mod = 257; p_gen = 3; p_pub = 3; p_priv = 1; p_factor = 1;

        // Reset state: p=257, g=3, y=3, x=1. 3*86 = 1 mod 257.
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b1, 31'd1, 31'd0, 31'd0, 1'b0}, 1'b1,
                             '{31'd3, 31'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b0, 31'd0, 31'd0, 31'd256, 1'b0}, 1'b1,
                             '{31'd0, 31'd254, 1'b0, 1'b0}});
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b0, 31'd0, 31'd0, 31'd257, 1'b0}, 1'b1,
                             '{31'd0, 31'd0, 1'b1, 1'b0}});
        dir_rows.push_back('{'{OP_DECRYPT, 1'b0, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1}, 1'b1,
                             '{31'd0, 31'd0, 1'b1, 1'b1}});
        // decrypt undoes the factor 3
        dir_rows.push_back('{'{OP_DECRYPT, 1'b1, 31'd0, 31'd3, 31'd254, 1'b0}, 1'b1,
                             '{31'd0, 31'd256, 1'b0, 1'b0}});
        // c1 at or above p is reduced first
        dir_rows.push_back('{'{OP_DECRYPT, 1'b1, 31'd0, 31'd260, 31'd254, 1'b1}, 1'b1,
                             '{31'd0, 31'd256, 1'b0, 1'b1}});
        // zero ephemeral gives c1 of one and a unit factor
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b1, 31'd0, 31'd0, 31'd5, 1'b0}, 1'b1,
                             '{31'd1, 31'd5, 1'b0, 1'b0}});
        // zero c1 gives a zero factor
        dir_rows.push_back('{'{OP_DECRYPT, 1'b1, 31'd0, 31'd0, 31'd7, 1'b1}, 1'b1,
                             '{31'd0, 31'd0, 1'b0, 1'b1}});
        // bad symbol on a first item still loads the factor
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b1, ALL_ONES, 31'd0, 31'd300, 1'b0},
                             1'b0, none});
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b0, 31'd0, 31'd0, 31'd255, 1'b1},
                             1'b0, none});
        dir_rows.push_back('{'{OP_DECRYPT, 1'b1, 31'd0, ALL_ONES, 31'd256, 1'b0},
                             1'b0, none});
        dir_rows.push_back('{'{OP_ENCRYPT, 1'b1, 31'h7FFF_FFFE, 31'h5555_5555, 31'd1, 1'b0},
                             1'b0, none});
        dir_rows.push_back('{'{OP_DECRYPT, 1'b0, 31'h2AAA_AAAA, 31'h2AAA_AAAA, 31'd128, 1'b1},
                             1'b0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_symbol(dir_rows[i].item, dir_rows[i].known, dir_rows[i].res);
        drain();

        // Settings per phase: largest and smallest modulus, keys at extremes
        mods[0] = 64'd2147483647; gens[0] = 31'd7;          privs[0] = 31'd1;
        mods[1] = 64'd257;        gens[1] = 31'd2;          privs[1] = ALL_ONES - 1;
        mods[2] = 64'd65537;      gens[2] = ALL_ONES - 1;   privs[2] = 31'd40000;
        mods[3] = 64'd1000003;    gens[3] = 31'd2;          privs[3] = 31'd12345;
        for (int k = 0; k < 4; k++)
            pubs[k] = word_t'(mod_pow(gens[k], privs[k], mods[k]));
        pubs[1] = 31'd1;
        pubs[2] = ALL_ONES - 1;

        for (phase = 0; phase < 4; phase++) begin
            write_reg(REG_MODULUS, word_t'(mods[phase]));
            write_reg(REG_GENERATOR, gens[phase]);
            write_reg(REG_PUBLIC, pubs[phase]);
            write_reg(REG_PRIVATE, privs[phase]);
            repeat (4) @(posedge clk);
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 58; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 58; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            n = 0;
            while (n < 160) begin
                // Mostly well-formed messages; now and then a stray non-first symbol
                if ($urandom_range(9) == 0) begin
                    it = '{1'($urandom_range(1)), 1'b0, word_t'($urandom), word_t'($urandom),
                           rand_symbol(1'($urandom_range(1)), p_mod),
                           1'($urandom_range(1))};
                    send_symbol(it, 1'b0, none);
                    n++;
                end else begin
                    len = $urandom_range(6, 20);
                    it.op = 1'($urandom_range(1));
                    for (j = 0; j < len; j++) begin
                        it.first = (j == 0);
                        it.eph = ($urandom_range(7) == 0) ? rand_word(p_mod) : word_t'($urandom);
                        it.c1 = rand_word(p_mod);
                        it.sym = rand_symbol(it.op, p_mod);
                        it.last = (j == len - 1);
                        send_symbol(it, 1'b0, none);
                        n++;
                        // long receiver hold-off while items keep coming
                        if (phase == 0 && n == 40) hold_req = 1'b1;
                    end
                end
            end
            drain();
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/emc_pkg.sv
rtl/core/emc_modmul.sv
rtl/core/elgamal_message_cipher.sv
sim/testbench.sv
